>>> hdl/aads_pkg.sv
// ============================================================================
// aads_pkg: shared types and constants for the alarm arm/disarm sequencer
// Mode codes, register indexes and reset defaults.
// ============================================================================
package aads_pkg;

    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 1;
    localparam int MS_PER_TICK_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 32'd100;
    localparam logic [CFG_W-1:0] GAP_RESET      = 32'd50;

    // Width of the precomputed timeout threshold (gap_limit + 1) * ms_per_tick
    function automatic int thr_width(input int ms_per_tick);
        return CFG_W + 1 + $clog2(ms_per_tick + 1);
    endfunction

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 1'b0,
        REG_GAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_ARMED = 3'd0,
        MODE_ARM1  = 3'd1,
        MODE_ARM2  = 3'd2,
        MODE_ARM3  = 3'd3,
        MODE_DIS1  = 3'd4,
        MODE_DIS2  = 3'd5,
        MODE_DIS3  = 3'd6,
        MODE_OFF   = 3'd7
    } mode_t;

endpackage

>>> hdl/aads_cfg.sv
// ============================================================================
// aads_cfg: configuration registers
// Holds the debounce hold-off and a timeout threshold scaled to ticks.
// ============================================================================
module aads_cfg
    import aads_pkg::*;
#(
    parameter int MS_PER_TICK = MS_PER_TICK_DEF,
    parameter int THR_W       = thr_width(MS_PER_TICK_DEF)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [CFG_W-1:0]     debounce_ticks,
    output logic [THR_W-1:0]     gap_thr
);

    localparam logic [THR_W-1:0] MS_K      = THR_W'(MS_PER_TICK);
    localparam logic [THR_W-1:0] THR_RESET = (THR_W'(GAP_RESET) + THR_W'(1)) * MS_K;

    logic [CFG_W-1:0] debounce_reg;
    logic [THR_W-1:0] gap_thr_reg;
    logic [THR_W-1:0] gap_thr_next;

    // floor(elapsed / ms) > gap  <=>  elapsed >= (gap + 1) * ms
    assign gap_thr_next = (THR_W'(cfg_wdata) + THR_W'(1)) * MS_K;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            gap_thr_reg  <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE:  debounce_reg <= cfg_wdata;
                REG_GAP_LIMIT: gap_thr_reg  <= gap_thr_next;
                default: ;
            endcase
        end
    end

    assign debounce_ticks = debounce_reg;
    assign gap_thr        = gap_thr_reg;

endmodule

>>> hdl/aads_core.sv
// ============================================================================
// aads_core: per-poll sequencer step
// Debounce, gap timeout and mode/indicator update; state doubles as result.
// ============================================================================
module aads_core
    import aads_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int THR_W     = thr_width(MS_PER_TICK_DEF)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [31:0]      now_ticks,
    input  logic             arm_level,
    input  logic             presence_level,
    input  logic [CFG_W-1:0] debounce_ticks,
    input  logic [THR_W-1:0] gap_thr,
    output mode_t            mode,
    output logic             alarm_lit
);

    localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

    mode_t                mode_reg, mode_next;
    logic                 indicator_reg, indicator_next;
    logic [TIME_BITS-1:0] arm_hold_reg, pres_hold_reg, last_press_reg;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] hold_sum;
    logic [TIME_BITS-1:0] elapsed;
    logic                 press_acc;
    logic                 pres_acc;
    logic                 expired;
    logic                 in_arming;
    logic                 in_disarming;

    assign now_t     = TIME_BITS'(now_ticks);
    assign hold_sum  = now_t + TIME_BITS'(debounce_ticks);
    assign elapsed   = now_t - last_press_reg;
    assign expired   = CMP_W'(elapsed) >= CMP_W'(gap_thr);
    assign press_acc = !arm_level && (now_t > arm_hold_reg);
    assign pres_acc  = presence_level && (now_t > pres_hold_reg);

    assign in_arming    = (mode_reg == MODE_ARM1) || (mode_reg == MODE_ARM2) ||
                          (mode_reg == MODE_ARM3);
    assign in_disarming = (mode_reg == MODE_DIS1) || (mode_reg == MODE_DIS2) ||
                          (mode_reg == MODE_DIS3);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (press_acc)
        begin
            unique case (mode_reg)
                MODE_OFF:   mode_next = MODE_ARM1;
                MODE_ARM1:  mode_next = MODE_ARM2;
                MODE_ARM2:  mode_next = MODE_ARM3;
                MODE_ARM3:  mode_next = MODE_ARMED;
                MODE_ARMED: mode_next = MODE_DIS1;
                MODE_DIS1:  mode_next = MODE_DIS2;
                MODE_DIS2:  mode_next = MODE_DIS3;
                MODE_DIS3:  mode_next = MODE_OFF;
                default:    mode_next = MODE_OFF;
            endcase
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_ARM1, MODE_ARM2, MODE_ARM3:
                    if (expired) mode_next = MODE_OFF;
                MODE_DIS1, MODE_DIS2, MODE_DIS3:
                    if (expired) mode_next = MODE_ARMED;
                default:
                    mode_next = mode_reg;
            endcase
        end
    end

    // indicator: dark on any transition, lit on debounced presence while armed
    always_comb
    begin
        indicator_next = indicator_reg;
        if (press_acc)
            indicator_next = 1'b0;
        else if ((in_arming || in_disarming) && expired)
            indicator_next = 1'b0;
        else if ((mode_reg == MODE_ARMED) && pres_acc)
            indicator_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            indicator_reg  <= 1'b0;
            arm_hold_reg   <= '0;
            pres_hold_reg  <= '0;
            last_press_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            indicator_reg <= indicator_next;
            if (press_acc)
            begin
                arm_hold_reg   <= hold_sum;
                last_press_reg <= now_t;
            end
            else if ((mode_reg == MODE_ARMED) && pres_acc)
            begin
                pres_hold_reg <= hold_sum;
            end
        end
    end

    assign mode      = mode_reg;
    assign alarm_lit = indicator_reg;

    // ---- assertions ----
    a_lit_only_armed: assert property (@(posedge clk) disable iff (!rst_n)
        indicator_reg |-> (mode_reg == MODE_ARMED))
        else $error("alarm lit outside armed mode");

    a_press_darkens: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && press_acc) |=> !indicator_reg)
        else $error("accepted press left alarm lit");

    a_arm_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !press_acc && in_arming && expired) |=> (mode_reg == MODE_OFF))
        else $error("arming timeout did not return to off");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(mode_reg) && $stable(indicator_reg) &&
                      $stable(last_press_reg)))
        else $error("state changed without a poll");

endmodule

>>> hdl/alarm_arm_disarm_sequencer.sv
// ============================================================================
// alarm_arm_disarm_sequencer: top level
// Path from input beat to result beat: the input register, then the
//   sequencer step writes the state/result register.
// Throughput: 1 beat per cycle if out_ready allows; a few compares, one adder.
// Reset: asynchronous, active low; mode off, alarm dark, hold-offs and last
//   press time zero, debounce 100 ticks, gap limit 50 ms.
// ============================================================================
module alarm_arm_disarm_sequencer
    import aads_pkg::*;
#(
    parameter int MS_PER_TICK = MS_PER_TICK_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // poll beats
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          now_ticks,
    input  logic                 arm_level,
    input  logic                 presence_level,
    // result beats
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 alarm_lit,
    output logic [2:0]           mode
);

    localparam int THR_W = thr_width(MS_PER_TICK);

    // Input stage register
    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic        s1_arm_reg;
    logic        s1_pres_reg;

    // Result valid; the payload is the sequencer state itself, which only
    // moves when a result is loaded, so it holds while the sink stalls.
    logic        out_valid_reg;

    logic             advance;
    logic             step_en;
    logic             in_fire;
    logic [CFG_W-1:0] debounce_ticks;
    logic [THR_W-1:0] gap_thr;
    mode_t            mode_q;

    assign advance  = !out_valid_reg || out_ready;
    assign step_en  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_now_reg  <= now_ticks;
            s1_arm_reg  <= arm_level;
            s1_pres_reg <= presence_level;
        end
    end

    aads_cfg #(
        .MS_PER_TICK (MS_PER_TICK),
        .THR_W       (THR_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .debounce_ticks (debounce_ticks),
        .gap_thr        (gap_thr)
    );

    aads_core #(
        .TIME_BITS (TIME_BITS),
        .THR_W     (THR_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .now_ticks      (s1_now_reg),
        .arm_level      (s1_arm_reg),
        .presence_level (s1_pres_reg),
        .debounce_ticks (debounce_ticks),
        .gap_thr        (gap_thr),
        .mode           (mode_q),
        .alarm_lit      (alarm_lit)
    );

    assign out_valid = out_valid_reg;
    assign mode      = mode_q;

endmodule

>>> tb/sv/alarm_arm_disarm_sequencer_tb.sv
// ============================================================================
// alarm_arm_disarm_sequencer_tb: self-checking testbench
// A short table of directed polls (reset state, both time extremes, hold-off
// wrap, arm/disarm sequences, timeouts, presence) runs first. Random polls
// follow over several debounce/gap settings, the extremes among them. Each
// result beat is checked against the table's result where one is typed, else against an in-bench model.
// ============================================================================
module alarm_arm_disarm_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aads_pkg::*;

    localparam int          CLK_HALF        = 6;
    localparam int          RESET_CYCLES    = 7;
    localparam int          N_PHASES        = 9;
    localparam int          POLLS_PER_PHASE = 215;
    localparam int          DRAIN_CYCLES    = 4;     // pipeline is two stages deep
    localparam int          SQUEEZE_PHASE   = 5;
    localparam int          SQUEEZE_CYCLES  = 48;
    localparam int          RUN_LIMIT_NS    = 6_000_000;
    localparam int          N_DIRECTED      = 24;
    localparam logic [31:0] TICK_MS         = MS_PER_TICK_DEF;

    // One result beat: alarm indicator and mode after the poll
    typedef struct packed {
        logic  lit;
        mode_t md;
    } result_t;

    // One directed poll; res is only used where typed is set
    typedef struct packed {
        logic [31:0] now;
        logic        arm;
        logic        pres;
        logic        typed;
        result_t     res;
    } poll_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          now_ticks;
    logic                 arm_level;
    logic                 presence_level;
    logic                 out_valid;
    logic                 out_ready;
    logic                 alarm_lit;
    logic [2:0]           mode;

    // Sequencer model state and its copy of the registers
    mode_t       seq_mode;
    logic [31:0] arm_until;
    logic [31:0] pres_until;
    logic [31:0] last_press_t;
    logic        lit_q;
    logic [31:0] debounce_q;
    logic [31:0] gap_q;

    result_t     alarm_expect_q[$];

    // Run control shared between processes
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          squeeze_req;

    int          err_count;
    int          polls_sent;
    int          beats_checked;
    int          lit_beats;
    int          in_stall_cycles;
    int          settings_run;
    logic [7:0]  modes_seen;

    // Directed polls. Default debounce 100 ticks, gap limit 50 ms = 500 ticks.
    poll_row_t dir_rows [N_DIRECTED] = '{
        // after reset: off and dark, a press at tick 0 is not past hold-off 0
        '{32'd0,          1'b1, 1'b0, 1'b1, '{1'b0, MODE_OFF}},
        '{32'd0,          1'b0, 1'b0, 1'b1, '{1'b0, MODE_OFF}},
        '{32'd1,          1'b0, 1'b0, 1'b1, '{1'b0, MODE_ARM1}},
        // press exactly at hold-off end is rejected
        '{32'd101,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd102,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd300,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd500,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        // armed: presence lights, second presence inside hold-off ignored
        '{32'd550,        1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd600,        1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd700,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        // gap right at the limit, then just past it: back to armed
        '{32'd1201,       1'b1, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd1210,       1'b1, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd1300,       1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        // press and presence together: press wins, alarm goes dark
        '{32'd1400,       1'b0, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd1501,       1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd1602,       1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd1703,       1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        // arming started, then aborted by timeout back to off
        '{32'd1804,       1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd2400,       1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        // top of the time range; hold-off sum wraps to 99
        '{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, '{1'b0, MODE_ARM1}},
        '{32'h0000_0000,  1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        // wrapped hold-off lets this press through early
        '{32'd100,        1'b0, 1'b0, 1'b0, '{1'b0, MODE_OFF}},
        '{32'd150,        1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}},
        '{32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, '{1'b0, MODE_OFF}}
    };

    alarm_arm_disarm_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ticks      (now_ticks),
        .arm_level      (arm_level),
        .presence_level (presence_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alarm_lit      (alarm_lit),
        .mode           (mode)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Sequencer model: one poll in, the indicator and mode after it out.
    // The timeout compare uses the press time from before this poll; it only
    // matters when no press was taken.
    // ------------------------------------------------------------------------
    function automatic result_t advance_sequencer(input logic [31:0] t,
                                                  input logic arm,
                                                  input logic pres);
        result_t     r;
        logic [31:0] elapsed;
        logic        expired;
        elapsed = t - last_press_t;
        expired = (elapsed / TICK_MS) > gap_q;
        if (!arm && t > arm_until) begin
            // plain unsigned compare; sum wraps mod 2^32
            arm_until    = t + debounce_q;
            last_press_t = t;
            lit_q        = 1'b0;
            case (seq_mode)
                MODE_OFF:   seq_mode = MODE_ARM1;
                MODE_ARM1:  seq_mode = MODE_ARM2;
                MODE_ARM2:  seq_mode = MODE_ARM3;
                MODE_ARM3:  seq_mode = MODE_ARMED;
                MODE_ARMED: seq_mode = MODE_DIS1;
                MODE_DIS1:  seq_mode = MODE_DIS2;
                MODE_DIS2:  seq_mode = MODE_DIS3;
                default:    seq_mode = MODE_OFF;
            endcase
        end else if (seq_mode inside {MODE_ARM1, MODE_ARM2, MODE_ARM3}) begin
            if (expired) begin
                seq_mode = MODE_OFF;
                lit_q    = 1'b0;
            end
        end else if (seq_mode inside {MODE_DIS1, MODE_DIS2, MODE_DIS3}) begin
            if (expired) begin
                seq_mode = MODE_ARMED;
                lit_q    = 1'b0;
            end
        end else if (seq_mode == MODE_ARMED && pres && t > pres_until) begin
            pres_until = t + debounce_q;
            lit_q      = 1'b1;
        end
        r.lit = lit_q;
        r.md  = seq_mode;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Poll sender: optional idle burst, then hold valid with a stable payload
    // until the beat is taken. The expectation is queued at the accepting
    // edge, which is always ahead of its result beat.
    // ------------------------------------------------------------------------
    task automatic send_poll(input logic [31:0] t, input logic arm, input logic pres,
                             input logic typed, input result_t typed_res);
        result_t r;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        now_ticks      <= t;
        arm_level      <= arm;
        presence_level <= pres;
        @(posedge clk);
        while (!in_ready) begin
            in_stall_cycles++;
            @(posedge clk);
        end
        r = advance_sequencer(t, arm, pres);
        alarm_expect_q.push_back(typed ? typed_res : r);
        polls_sent++;
    endtask

    // Both registers back to back; write enable stays high across the two
    task automatic apply_setting(input logic [31:0] deb, input logic [31:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge clk);
        debounce_q = deb;
        cfg_index <= REG_GAP_LIMIT;
        cfg_wdata <= gap;
        @(posedge clk);
        gap_q = gap;
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready bursts, plus one long hold-off on request so
    // the pipeline fills and backs up into in_ready.
    // ------------------------------------------------------------------------
    initial begin : result_ready_gen
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (squeeze_req) begin
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Result checker: each beat against the oldest expectation
    initial begin : result_checker
        result_t want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
                beats_checked++;
                modes_seen[mode] = 1'b1;
                if (alarm_lit === 1'b1)
                    lit_beats++;
                if (alarm_expect_q.size() == 0) begin
                    flag_error($sformatf("result beat with nothing expected: lit=%b mode=%0d",
                                         alarm_lit, mode));
                end else begin
                    want = alarm_expect_q.pop_front();
                    if (want.lit !== alarm_lit || want.md !== mode)
                        flag_error($sformatf("mismatch: lit exp %b got %b, mode exp %0d got %0d",
                                             want.lit, alarm_lit, want.md, mode));
                end
            end
        end
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("[alarm_arm_disarm_sequencer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases, each after the
    // first with a new register setting. Registers change only with the pipeline empty.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0]     tick_now;
        logic [31:0]     deb;
        logic [31:0]     gap;
        longint unsigned span;
        int              pick;
        logic            arm;
        logic            pres;

        // every input known from time zero
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DEBOUNCE;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        now_ticks      = '0;
        arm_level      = 1'b1;
        presence_level = 1'b0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        squeeze_req    = 1'b0;
        modes_seen     = '0;

        // model at its reset values
        seq_mode     = MODE_OFF;
        arm_until    = '0;
        pres_until   = '0;
        last_press_t = '0;
        lit_q        = 1'b0;
        debounce_q   = DEBOUNCE_RESET;
        gap_q        = GAP_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_poll(dir_rows[i].now, dir_rows[i].arm, dir_rows[i].pres,
                      dir_rows[i].typed, dir_rows[i].res);

        tick_now = 32'd5000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                in_valid <= 1'b0;
                while (alarm_expect_q.size() != 0) @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                case (ph)
                    1:       apply_setting(32'd0, 32'd0);
                    2:       apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    3:       apply_setting(32'd0, 32'hFFFF_FFFF);
                    4:       apply_setting(32'hFFFF_FFFF, 32'd0);
                    5:       apply_setting($urandom_range(1, 300), $urandom_range(1, 80));
                    6:       apply_setting($urandom_range(0, 1000), $urandom_range(0, 200));
                    7:       apply_setting(32'd3, 32'd2);
                    default: apply_setting(DEBOUNCE_RESET, GAP_RESET);
                endcase
            end
            // last phase runs with both sides always willing
            if (ph == N_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end

            // time steps scaled to the setting so full sequences complete often
            deb  = debounce_q;
            gap  = gap_q;
            span = 64'(deb);
            span = span + 64'd10 * gap;
            if (span < 64'd16)
                span = 64'd16;
            if (span > 64'd2000)
                span = 64'd2000;

            for (int k = 0; k < POLLS_PER_PHASE; k++) begin
                if (ph == SQUEEZE_PHASE && k == 40)
                    squeeze_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    tick_now = $urandom();                       // noise: any time
                else if (pick < 6)
                    tick_now = tick_now + 32'(span) + $urandom_range(0, 32'(4 * span));
                else if (pick < 7)
                    tick_now = 32'hFFFF_FFFF - $urandom_range(0, 32'(span));  // near wrap
                else
                    tick_now = tick_now + $urandom_range(0, 32'(span / 2));
                arm  = 1'($urandom_range(0, 1));
                pres = 1'($urandom_range(0, 1));
                send_poll(tick_now, arm, pres, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (alarm_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d polls (%0d directed) over %0d register settings plus reset values",
                 polls_sent, N_DIRECTED, settings_run);
        $display("Checked %0d result beats, %0d lit, modes seen %b, input held off %0d cycles",
                 beats_checked, lit_beats, modes_seen, in_stall_cycles);
        if (err_count == 0)
            $display("[alarm_arm_disarm_sequencer] OK");
        else
            $display("[alarm_arm_disarm_sequencer] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/aads_pkg.sv
hdl/aads_cfg.sv
hdl/aads_core.sv
hdl/alarm_arm_disarm_sequencer.sv
tb/sv/alarm_arm_disarm_sequencer_tb.sv
